>>> hdl/ght_pkg.sv
// Shared types and constants for the generational handle cancel table.
// No dependencies; imported by generational_handle_cancel_table and its testbench.
package ght_pkg;

	localparam int SLOTS_DEF = 1024;
	localparam logic [31:0] NONE_HANDLE = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		CMD_ALLOC        = 3'd0,
		CMD_ALLOC_PARENT = 3'd1,
		CMD_RELEASE      = 3'd2,
		CMD_OWNER_CANCEL = 3'd3,
		CMD_CANCEL       = 3'd4,
		CMD_CHECK        = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// one slot entry: generation, cancel mark, parent handle
	typedef struct packed {
		logic [15:0] gen;
		logic        mark;
		logic [31:0] parent;
	} slot_t;

endpackage

>>> hdl/generational_handle_cancel_table.sv
// Generational handle cancel table: slot memory, free-list memory and command logic.
// Depends on ght_pkg.
//
//  channel | signals                                  | direction | accepted when
//  in      | in_valid, in_ready, command, handle      | to block  | in_valid & in_ready
//  out     | out_valid, out_ready, new_handle, ok,    | from block| out_valid & out_ready
//          | cancelled, parent_handle                 |           |
//
// Each item is accepted in ST_IDLE, where the memory reads are issued, and is modified and
// written back in ST_EXEC, as set by the registered reads of the slot memory.
// After reset a clearing pass initializes every entry of both memories; in_ready is low.
// The write-back cycle stalls while the previous result still waits on the output.
// Only one item is in flight, so no read can meet a pending write to the same entry.
module generational_handle_cancel_table
	import ght_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [31:0] handle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] new_handle,
	output logic        ok,
	output logic        cancelled,
	output logic [31:0] parent_handle
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HW = $clog2(SLOTS + 1);

	state_t state_q, state_d;

	logic [HW-1:0] free_head_q;
	logic [IW-1:0] clr_q;
	logic [2:0]    cmd_s1;
	logic [31:0]   handle_s1;

	slot_t         slot_mem [SLOTS];
	logic [HW-1:0] nf_mem   [SLOTS];
	slot_t         slot_a_s1, slot_b_s1;
	logic [HW-1:0] nf_a_s1;

	logic          out_valid_q;
	logic [31:0]   new_handle_q, parent_q;
	logic          ok_q, cancelled_q;

	logic          accept, exec_fire, clearing;
	logic [HW-1:0] head_m1;
	logic [IW-1:0] head_slot, addr_a;

	logic          slot_we, nf_we;
	logic [IW-1:0] slot_waddr, nf_waddr;
	slot_t         slot_wdata;
	logic [HW-1:0] nf_wdata;
	logic          head_we;
	logic [HW-1:0] head_wdata;

	logic [31:0]   res_new, res_par;
	logic          res_ok, res_canc;
	logic          idx_ok, cur, head_ok;
	logic [IW-1:0] idx_s1, alloc_slot;
	logic [HW-1:0] alloc_m1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == IW'(SLOTS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_EXEC;
			ST_EXEC:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = 1'b0;
		clearing  = 1'b0;
		exec_fire = 1'b0;
		case (state_q)
			ST_CLEAR: clearing = 1'b1;
			ST_IDLE:  in_ready = 1'b1;
			ST_EXEC:  exec_fire = !out_valid_q || out_ready;
			default:  ;
		endcase
	end

	assign accept    = in_valid && in_ready;
	assign head_m1   = free_head_q - HW'(1);
	assign head_slot = head_m1[IW-1:0];
	assign addr_a    = (command inside {CMD_ALLOC, CMD_ALLOC_PARENT}) ?
		head_slot : handle[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			free_head_q <= HW'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + IW'(1);
			if (head_we) free_head_q <= head_wdata;
			if (exec_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// hold the item for the write-back cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= command;
			handle_s1 <= handle;
		end
	end

	// memories: registered reads at accept, one write port each
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_a_s1 <= slot_mem[addr_a];
			slot_b_s1 <= slot_mem[handle[IW-1:0]];
		end
		if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
	end

	always_ff @(posedge clk) begin
		if (accept) nf_a_s1 <= nf_mem[addr_a];
		if (nf_we) nf_mem[nf_waddr] <= nf_wdata;
	end

	// read-modify-write of the slot the item addresses
	assign idx_s1     = handle_s1[IW-1:0];
	assign idx_ok     = (handle_s1 != NONE_HANDLE) && (32'(handle_s1[15:0]) < 32'(SLOTS));
	assign cur        = idx_ok && (slot_b_s1.gen == handle_s1[31:16]);
	assign head_ok    = (free_head_q != '0) && (32'(free_head_q) <= 32'(SLOTS));
	assign alloc_m1   = free_head_q - HW'(1);
	assign alloc_slot = alloc_m1[IW-1:0];

	always_comb begin
		res_new    = NONE_HANDLE;
		res_ok     = 1'b0;
		res_canc   = 1'b0;
		res_par    = NONE_HANDLE;
		slot_we    = 1'b0;
		slot_waddr = idx_s1;
		slot_wdata = slot_a_s1;
		nf_we      = 1'b0;
		nf_waddr   = idx_s1;
		nf_wdata   = free_head_q;
		head_we    = 1'b0;
		head_wdata = nf_a_s1;

		if (clearing) begin
			slot_we    = 1'b1;
			slot_waddr = clr_q;
			slot_wdata = '{gen: 16'h0, mark: 1'b0, parent: NONE_HANDLE};
			nf_we      = 1'b1;
			nf_waddr   = clr_q;
			nf_wdata   = (clr_q == IW'(SLOTS - 1)) ? '0 : HW'(clr_q) + HW'(2);
		end else if (exec_fire) begin
			case (cmd_t'(cmd_s1))
				CMD_ALLOC, CMD_ALLOC_PARENT: begin
					if (head_ok) begin
						// pop the head; keep generation and mark, store parent if current
						head_we    = 1'b1;
						head_wdata = nf_a_s1;
						slot_we    = 1'b1;
						slot_waddr = alloc_slot;
						slot_wdata.parent = (cmd_t'(cmd_s1) == CMD_ALLOC_PARENT && cur) ?
							handle_s1 : NONE_HANDLE;
						res_new = {slot_a_s1.gen, 16'(alloc_slot)};
						res_ok  = 1'b1;
					end
				end
				CMD_RELEASE: begin
					if (idx_ok) begin
						slot_we    = 1'b1;
						slot_wdata = '{gen: slot_a_s1.gen + 16'd1, mark: 1'b0,
							parent: NONE_HANDLE};
						nf_we      = 1'b1;
						head_we    = 1'b1;
						head_wdata = HW'(idx_s1) + HW'(1);
						res_ok     = 1'b1;
					end
				end
				CMD_OWNER_CANCEL: begin
					if (idx_ok) begin
						slot_we         = 1'b1;
						slot_wdata.mark = 1'b1;
						res_ok          = 1'b1;
						res_canc        = 1'b1;
					end
				end
				CMD_CANCEL: begin
					if (cur) begin
						slot_we         = 1'b1;
						slot_wdata.mark = 1'b1;
						res_ok          = 1'b1;
						res_canc        = 1'b1;
					end
				end
				CMD_CHECK: begin
					if (cur) begin
						res_ok   = 1'b1;
						res_canc = slot_a_s1.mark;
						res_par  = slot_a_s1.parent;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			new_handle_q <= res_new;
			ok_q         <= res_ok;
			cancelled_q  <= res_canc;
			parent_q     <= res_par;
		end
	end

	assign out_valid     = out_valid_q;
	assign new_handle    = new_handle_q;
	assign ok            = ok_q;
	assign cancelled     = cancelled_q;
	assign parent_handle = parent_q;

endmodule

>>> sim/generational_handle_cancel_table_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for generational_handle_cancel_table: a directed table of commands, then
// random allocate/release/cancel/check traffic, scored by fixed replies or the in-bench model.
// Depends on ght_pkg and the RTL of the block; needs nothing else.
module generational_handle_cancel_table_tb;
	import ght_pkg::*;

	localparam int TABLE_SLOTS = SLOTS_DEF;
	localparam logic [2:0] CMD_UNDEF_A = 3'd6;
	localparam logic [2:0] CMD_UNDEF_B = 3'd7;
	localparam int RANDOM_ITEMS = 700;
	localparam int TAIL_ITEMS = 100;

	typedef struct packed {
		logic [31:0] new_handle;
		logic        ok;
		logic        cancelled;
		logic [31:0] parent_handle;
	} reply_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] h;
		logic        known;
		reply_t      want;
	} plan_row_t;

	localparam reply_t WORKED_OUT = '{NONE_HANDLE, 1'b0, 1'b0, NONE_HANDLE};
	localparam reply_t REFUSED = '{NONE_HANDLE, 1'b0, 1'b0, NONE_HANDLE};

	// directed part; rows with known = 0 are scored by the slot table model
	localparam int PLAN_ROWS = 26;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{CMD_CHECK,        32'h0000_0000, 1'b1, '{NONE_HANDLE, 1'b1, 1'b0, NONE_HANDLE}},
		'{CMD_ALLOC,        32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, NONE_HANDLE}},
		'{CMD_ALLOC_PARENT, 32'h0000_0000, 1'b0, WORKED_OUT},
		'{CMD_CHECK,        32'h0000_0001, 1'b0, WORKED_OUT},
		'{CMD_ALLOC_PARENT, NONE_HANDLE,   1'b1, '{32'h0000_0002, 1'b1, 1'b0, NONE_HANDLE}},
		'{CMD_ALLOC_PARENT, 32'h0001_0000, 1'b0, WORKED_OUT},
		'{CMD_CHECK,        32'h0000_0003, 1'b0, WORKED_OUT},
		'{CMD_OWNER_CANCEL, 32'h1234_0003, 1'b0, WORKED_OUT},
		'{CMD_CHECK,        32'h0000_0003, 1'b0, WORKED_OUT},
		'{CMD_CANCEL,       32'h0001_0002, 1'b1, REFUSED},
		'{CMD_CANCEL,       32'h0000_0002, 1'b0, WORKED_OUT},
		'{CMD_CANCEL,       NONE_HANDLE,   1'b1, REFUSED},
		'{CMD_OWNER_CANCEL, NONE_HANDLE,   1'b1, REFUSED},
		'{CMD_OWNER_CANCEL, 32'h0000_FFFF, 1'b1, REFUSED},
		'{CMD_OWNER_CANCEL, 32'h0000_0400, 1'b1, REFUSED},
		'{CMD_RELEASE,      32'h0000_0002, 1'b0, WORKED_OUT},
		'{CMD_CHECK,        32'h0000_0002, 1'b1, REFUSED},
		'{CMD_CHECK,        32'h0001_0002, 1'b0, WORKED_OUT},
		'{CMD_ALLOC,        32'h0000_0000, 1'b0, WORKED_OUT},
		'{CMD_RELEASE,      NONE_HANDLE,   1'b1, REFUSED},
		'{CMD_RELEASE,      32'hFFFF_0400, 1'b1, REFUSED},
		'{CMD_UNDEF_A,      32'h0000_0000, 1'b1, REFUSED},
		'{CMD_UNDEF_B,      NONE_HANDLE,   1'b1, REFUSED},
		'{CMD_CHECK,        32'hFFFF_0000, 1'b1, REFUSED},
		'{CMD_RELEASE,      32'hABCD_0001, 1'b0, WORKED_OUT},
		'{CMD_CANCEL,       32'h0000_0001, 1'b1, REFUSED}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  command = 3'd0;
	logic [31:0] handle = 32'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] new_handle;
	logic        ok;
	logic        cancelled;
	logic [31:0] parent_handle;

	// slot table model
	logic [10:0] free_top;
	logic [10:0] link_next [TABLE_SLOTS];
	logic [15:0] slot_gen [TABLE_SLOTS];
	bit          slot_mark [TABLE_SLOTS];
	logic [31:0] slot_parent [TABLE_SLOTS];

	reply_t pending_replies [$];
	int     held_slots [$];
	bit     is_held [TABLE_SLOTS];
	bit     calm = 1'b0;
	int     mismatches = 0;

	generational_handle_cancel_table #(
		.SLOTS(TABLE_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.handle(handle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.new_handle(new_handle),
		.ok(ok),
		.cancelled(cancelled),
		.parent_handle(parent_handle)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic table_clear();
		free_top = 11'd1;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			link_next[i] = 11'(i + 2);
			slot_gen[i] = 16'd0;
			slot_mark[i] = 1'b0;
			slot_parent[i] = NONE_HANDLE;
		end
		link_next[TABLE_SLOTS - 1] = 11'd0;
	endtask

	// apply one command to the model and return the reply it gives
	function automatic reply_t table_step(input logic [2:0] cmd, input logic [31:0] h);
		reply_t r;
		logic [15:0] idx;
		bit in_range;
		bit current;
		int s;
		r = '{NONE_HANDLE, 1'b0, 1'b0, NONE_HANDLE};
		idx = h[15:0];
		in_range = idx < TABLE_SLOTS;
		current = in_range ? (slot_gen[idx[9:0]] == h[31:16]) : 1'b0;
		case (cmd)
			CMD_ALLOC, CMD_ALLOC_PARENT: begin
				if (free_top != 11'd0 && free_top <= TABLE_SLOTS) begin
					s = int'(free_top) - 1;
					free_top = link_next[s];
					slot_parent[s] = (cmd == CMD_ALLOC_PARENT && current) ? h : NONE_HANDLE;
					r.new_handle = {slot_gen[s], 16'(s)};
					r.ok = 1'b1;
				end
			end
			CMD_RELEASE: begin
				if (h != NONE_HANDLE && in_range) begin
					slot_gen[idx[9:0]] = slot_gen[idx[9:0]] + 16'd1;
					slot_mark[idx[9:0]] = 1'b0;
					slot_parent[idx[9:0]] = NONE_HANDLE;
					link_next[idx[9:0]] = free_top;
					free_top = 11'(idx + 16'd1);
					r.ok = 1'b1;
				end
			end
			CMD_OWNER_CANCEL: begin
				if (h != NONE_HANDLE && in_range) begin
					slot_mark[idx[9:0]] = 1'b1;
					r.ok = 1'b1;
					r.cancelled = 1'b1;
				end
			end
			CMD_CANCEL: begin
				if (h != NONE_HANDLE && current) begin
					slot_mark[idx[9:0]] = 1'b1;
					r.ok = 1'b1;
					r.cancelled = 1'b1;
				end
			end
			CMD_CHECK: begin
				if (current) begin
					r.ok = 1'b1;
					r.cancelled = slot_mark[idx[9:0]];
					r.parent_handle = slot_parent[idx[9:0]];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_held();
		return held_slots[$urandom_range(held_slots.size() - 1)];
	endfunction

	function automatic logic [31:0] live_handle();
		int s;
		s = pick_held();
		return {slot_gen[s], 16'(s)};
	endfunction

	function automatic logic [31:0] outside_handle();
		return $urandom_range(1) ? NONE_HANDLE
			: {16'($urandom), 16'($urandom_range(16'hFFFF, TABLE_SLOTS))};
	endfunction

	function automatic logic [31:0] stray_handle();
		logic [15:0] s;
		s = 16'($urandom_range(TABLE_SLOTS - 1));
		case ($urandom_range(4))
			0: return NONE_HANDLE;
			1: return $urandom;
			2: return outside_handle();
			3: return {slot_gen[s[9:0]] - 16'd1, s};  // one generation behind
			default: return {16'($urandom), s};
		endcase
	endfunction

	// loose allows release of any slot, free ones included
	task automatic draw_item(input bit loose, output logic [2:0] c, output logic [31:0] h);
		int r;
		bit have;
		r = $urandom_range(99);
		have = held_slots.size() != 0;
		h = $urandom;
		// with no slot held, every command that needs a live handle turns into an allocate
		if (r < 25 || (!have && r < 96)) begin
			c = CMD_ALLOC;
		end else if (r < 40) begin
			c = CMD_ALLOC_PARENT;
			h = ($urandom_range(9) < 7) ? live_handle() : stray_handle();
		end else if (r < 60) begin
			c = CMD_RELEASE;
			if (loose)
				h = $urandom_range(1) ? live_handle() : stray_handle();
			else if ($urandom_range(9) < 7)
				h = live_handle();
			else if ($urandom_range(1))
				h = {16'($urandom), 16'(pick_held())};
			else
				h = outside_handle();
		end else if (r < 70) begin
			c = CMD_OWNER_CANCEL;
			h = $urandom_range(1) ? {16'($urandom), 16'(pick_held())} : stray_handle();
		end else if (r < 80) begin
			c = CMD_CANCEL;
			h = ($urandom_range(9) < 6) ? live_handle() : stray_handle();
		end else if (r < 96) begin
			c = CMD_CHECK;
			h = ($urandom_range(9) < 6) ? live_handle() : stray_handle();
		end else begin
			c = $urandom_range(1) ? CMD_UNDEF_A : CMD_UNDEF_B;
		end
	endtask

	// drive one item, wait for it to be taken, then record what it should return
	task automatic issue(input logic [2:0] c, input logic [31:0] h, input bit known,
			input reply_t want);
		reply_t worked;
		int idx;
		while (!calm && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		handle <= h;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		worked = table_step(c, h);
		pending_replies.push_back(known ? want : worked);
		if ((c == CMD_ALLOC || c == CMD_ALLOC_PARENT) && worked.ok) begin
			idx = int'(worked.new_handle[15:0]);
			if (!is_held[idx]) begin
				is_held[idx] = 1'b1;
				held_slots.push_back(idx);
			end
		end
		if (c == CMD_RELEASE && worked.ok && is_held[h[9:0]]) begin
			idx = int'(h[15:0]);
			is_held[idx] = 1'b0;
			for (int i = 0; i < held_slots.size(); i++) begin
				if (held_slots[i] == idx) begin
					held_slots.delete(i);
					break;
				end
			end
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("tb: %s mismatch at %0t: got %h, want %h", what, $realtime, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 7);
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_replies.size() == 0) begin
				flag_mismatch("unrequested item", new_handle, NONE_HANDLE);
			end else begin
				want = pending_replies.pop_front();
				if (new_handle !== want.new_handle)
					flag_mismatch("new_handle", new_handle, want.new_handle);
				if (ok !== want.ok)
					flag_mismatch("ok", 32'(ok), 32'(want.ok));
				if (cancelled !== want.cancelled)
					flag_mismatch("cancelled", 32'(cancelled), 32'(want.cancelled));
				if (parent_handle !== want.parent_handle)
					flag_mismatch("parent_handle", parent_handle, want.parent_handle);
			end
		end
	end

	initial begin
		logic [2:0] c;
		logic [31:0] h;
		int n;
		int extra;
		table_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < PLAN_ROWS; i++)
			issue(PLAN[i].cmd, PLAN[i].h, PLAN[i].known, PLAN[i].want);

		n = 0;
		while (n < RANDOM_ITEMS) begin
			calm = n >= 250 && n < 400;
			draw_item(1'b0, c, h);
			issue(c, h, 1'b0, WORKED_OUT);
			if (c <= CMD_CHECK)
				n++;
		end
		calm = 1'b0;

		// drain the free list, then knock on a full table a few times
		extra = 0;
		n = 0;
		while ((free_top != 11'd0 || extra < 3) && n < 1200) begin
			c = $urandom_range(1) ? CMD_ALLOC : CMD_ALLOC_PARENT;
			h = (held_slots.size() != 0 && $urandom_range(1)) ? live_handle() : stray_handle();
			issue(c, h, 1'b0, WORKED_OUT);
			if (free_top == 11'd0)
				extra++;
			n++;
		end

		// releases of any slot now, double releases included
		n = 0;
		while (n < TAIL_ITEMS) begin
			draw_item(1'b1, c, h);
			issue(c, h, 1'b0, WORKED_OUT);
			if (c <= CMD_CHECK)
				n++;
		end
		in_valid <= 1'b0;

		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
